// ===== sv/diff_drive_odometry_assert.svh =====
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Concurrent property checks used by the odometry top level.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH

// check cons in the same cycle as cond
`define DDO_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after cond
`define DDO_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// Odometry package
// Shared constants, command struct and sine table builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddo_pkg;

   localparam int TRIG_INDEX_BITS = 10;
   localparam int TRIG_SIZE = 1 << TRIG_INDEX_BITS;
   localparam logic [TRIG_INDEX_BITS-1:0] QUARTER_IDX =
      TRIG_INDEX_BITS'(TRIG_SIZE / 4);

   localparam logic [23:0] LEFT_SCALE_RESET    = 24'd1264055;
   localparam logic [23:0] RIGHT_SCALE_RESET   = 24'd1263288;
   localparam logic [23:0] INVERSE_TRACK_RESET = 24'd66435;

   localparam logic [1:0] CSR_LEFT_SCALE    = 2'd0;
   localparam logic [1:0] CSR_RIGHT_SCALE   = 2'd1;
   localparam logic [1:0] CSR_INVERSE_TRACK = 2'd2;

   localparam logic [2:0] MUL_RC_RS   = 3'd0;
   localparam logic [2:0] MUL_LC_LS   = 3'd1;
   localparam logic [2:0] MUL_DLO_IT  = 3'd2;
   localparam logic [2:0] MUL_DHI_IT  = 3'd3;
   localparam logic [2:0] MUL_LLO_COS = 3'd4;
   localparam logic [2:0] MUL_LHI_COS = 3'd5;
   localparam logic [2:0] MUL_LLO_SIN = 3'd6;
   localparam logic [2:0] MUL_LHI_SIN = 3'd7;

   localparam logic [63:0] SC1 = 64'd1686629713;
   localparam logic [63:0] SC3 = 64'd693598668;
   localparam logic [63:0] SC5 = 64'd85569306;
   localparam logic [63:0] SC7 = 64'd5026995;
   localparam logic [63:0] SC9 = 64'd172272;

   typedef struct packed {
      logic       load_in;
      logic [2:0] mul_sel;
      logic       rom_cos;
      logic       ld_sin;
      logic       ld_cos;
      logic       ld_rdist;
      logic       ld_sum;
      logic       ld_part;
      logic       ld_ystep;
      logic       ld_delta;
      logic       ld_x;
      logic       ld_y;
      logic       ld_rsp;
   } dp_cmd_type;

   typedef logic signed [17:0] sine_tab_type [TRIG_SIZE];

   function automatic logic signed [17:0] quarter_sine(input logic [TRIG_INDEX_BITS-1:0] r);
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] t;
      logic [63:0] s;
      u  = 64'(r) << (30 - (TRIG_INDEX_BITS - 2));
      u2 = (u * u) >> 30;
      t  = SC9;
      t  = SC7 - ((u2 * t) >> 30);
      t  = SC5 - ((u2 * t) >> 30);
      t  = SC3 - ((u2 * t) >> 30);
      t  = SC1 - ((u2 * t) >> 30);
      s  = (u * t) >> 30;
      s  = (s + 64'd8192) >> 14;
      if (s > 64'd65536) begin
         s = 64'd65536;
      end
      return $signed(s[17:0]);
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type          tab;
      logic [TRIG_INDEX_BITS-1:0] kk;
      logic [TRIG_INDEX_BITS-1:0] r;
      logic [1:0]            q;
      logic signed [17:0]    v;
      for (int k = 0; k < TRIG_SIZE; k++) begin
         kk = TRIG_INDEX_BITS'(k);
         q  = kk[TRIG_INDEX_BITS-1 -: 2];
         r  = {2'b00, kk[TRIG_INDEX_BITS-3:0]};
         v  = q[0] ? quarter_sine(QUARTER_IDX - r) : quarter_sine(r);
         tab[k] = q[1] ? -v : v;
      end
      return tab;
   endfunction

endpackage

// ===== sv/ddo_ctrl.sv =====
// ----------------------------------------------------------------------------
// Odometry controller
// Sequences one request through the shared multiplier and the accumulators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ddo_pkg::dp_cmd_type cmd
);
   import ddo_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MRS  = 4'd1;
   localparam logic [3:0] S_MLS  = 4'd2;
   localparam logic [3:0] S_SUM  = 4'd3;
   localparam logic [3:0] S_DLO  = 4'd4;
   localparam logic [3:0] S_DHI  = 4'd5;
   localparam logic [3:0] S_CLO  = 4'd6;
   localparam logic [3:0] S_CHI  = 4'd7;
   localparam logic [3:0] S_SLO  = 4'd8;
   localparam logic [3:0] S_SHI  = 4'd9;
   localparam logic [3:0] S_DY   = 4'd10;
   localparam logic [3:0] S_ACC  = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_MRS;
            end
         end
         S_MRS: begin
            cmd.mul_sel = MUL_RC_RS;
            state_in    = S_MLS;
         end
         S_MLS: begin
            cmd.mul_sel  = MUL_LC_LS;
            cmd.rom_cos  = 1'b1;
            cmd.ld_sin   = 1'b1;
            cmd.ld_rdist = 1'b1;
            state_in     = S_SUM;
         end
         S_SUM: begin
            cmd.ld_cos = 1'b1;
            cmd.ld_sum = 1'b1;
            state_in   = S_DLO;
         end
         S_DLO: begin
            cmd.mul_sel = MUL_DLO_IT;
            state_in    = S_DHI;
         end
         S_DHI: begin
            cmd.mul_sel = MUL_DHI_IT;
            cmd.ld_part = 1'b1;
            state_in    = S_CLO;
         end
         S_CLO: begin
            cmd.mul_sel  = MUL_LLO_COS;
            cmd.ld_ystep = 1'b1;
            state_in     = S_CHI;
         end
         S_CHI: begin
            cmd.mul_sel = MUL_LHI_COS;
            cmd.ld_part = 1'b1;
            state_in    = S_SLO;
         end
         S_SLO: begin
            cmd.mul_sel  = MUL_LLO_SIN;
            cmd.ld_delta = 1'b1;
            state_in     = S_SHI;
         end
         S_SHI: begin
            cmd.mul_sel = MUL_LHI_SIN;
            cmd.ld_part = 1'b1;
            cmd.ld_x    = 1'b1;
            state_in    = S_DY;
         end
         S_DY: begin
            cmd.ld_delta = 1'b1;
            state_in     = S_ACC;
         end
         S_ACC: begin
            cmd.ld_y = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.ld_rsp = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.ld_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/ddo_datapath.sv =====
// ----------------------------------------------------------------------------
// Odometry datapath
// Registers, shared multiplier, sine ROM, pose accumulators and result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ddo_pkg::dp_cmd_type cmd,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [23:0]         csr_wdata,
   input  logic signed [15:0]  req_right_count,
   input  logic signed [15:0]  req_left_count,
   output logic signed [31:0]  rsp_pos_x,
   output logic signed [31:0]  rsp_pos_y,
   output logic [15:0]         rsp_yaw,
   output logic signed [39:0]  rsp_lin_step,
   output logic signed [31:0]  rsp_yaw_step
);
   import ddo_pkg::*;

   localparam sine_tab_type SINE_TAB = build_sine_tab();

   logic [23:0]        left_scale_ff;
   logic [23:0]        right_scale_ff;
   logic [23:0]        inv_track_ff;
   logic signed [15:0] right_cnt_ff;
   logic signed [15:0] left_cnt_ff;
   logic signed [49:0] prod_ff;
   logic signed [49:0] prod_in;
   logic signed [40:0] rdist_ff;
   logic signed [39:0] lin_ff;
   logic signed [39:0] lin_in;
   logic signed [41:0] diff_ff;
   logic signed [41:0] diff_in;
   logic signed [41:0] sum_full;
   logic signed [49:0] part_ff;
   logic signed [31:0] ystep_ff;
   logic signed [31:0] ystep_in;
   logic signed [43:0] delta_ff;
   logic signed [43:0] delta_in;
   logic signed [47:0] x_ff;
   logic signed [47:0] y_ff;
   logic [31:0]        heading_ff;
   logic signed [17:0] rom_q_ff;
   logic signed [17:0] sin_ff;
   logic signed [17:0] cos_ff;
   logic signed [24:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [73:0] comb_full;
   logic signed [57:0] yshift;
   logic [TRIG_INDEX_BITS-1:0] sin_idx;
   logic [TRIG_INDEX_BITS-1:0] rom_addr;
   logic signed [31:0] pos_x_ff;
   logic signed [31:0] pos_y_ff;
   logic [15:0]        yaw_ff;
   logic signed [39:0] lin_out_ff;
   logic signed [31:0] ystep_out_ff;

   function automatic logic signed [47:0] sat_pos(input logic signed [48:0] v);
      if (v[48] != v[47]) begin
         return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end
      return v[47:0];
   endfunction

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_RC_RS: begin
            mul_a = {{9{right_cnt_ff[15]}}, right_cnt_ff};
            mul_b = {1'b0, right_scale_ff};
         end
         MUL_LC_LS: begin
            mul_a = {{9{left_cnt_ff[15]}}, left_cnt_ff};
            mul_b = {1'b0, left_scale_ff};
         end
         MUL_DLO_IT: begin
            mul_a = {1'b0, diff_ff[23:0]};
            mul_b = {1'b0, inv_track_ff};
         end
         MUL_DHI_IT: begin
            mul_a = {{7{diff_ff[41]}}, diff_ff[41:24]};
            mul_b = {1'b0, inv_track_ff};
         end
         MUL_LLO_COS: begin
            mul_a = {1'b0, lin_ff[23:0]};
            mul_b = {{7{cos_ff[17]}}, cos_ff};
         end
         MUL_LHI_COS: begin
            mul_a = {{9{lin_ff[39]}}, lin_ff[39:24]};
            mul_b = {{7{cos_ff[17]}}, cos_ff};
         end
         MUL_LLO_SIN: begin
            mul_a = {1'b0, lin_ff[23:0]};
            mul_b = {{7{sin_ff[17]}}, sin_ff};
         end
         MUL_LHI_SIN: begin
            mul_a = {{9{lin_ff[39]}}, lin_ff[39:24]};
            mul_b = {{7{sin_ff[17]}}, sin_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign sum_full = {rdist_ff[40], rdist_ff} + {prod_ff[40], prod_ff[40:0]};
   assign lin_in   = sum_full[40:1];
   assign diff_in  = {rdist_ff[40], rdist_ff} - {prod_ff[40], prod_ff[40:0]};

   // merge high partial product (prod_ff) with low partial product (part_ff)
   assign comb_full = {prod_ff, 24'd0} + {{24{part_ff[49]}}, part_ff};
   assign yshift    = comb_full[73:16];
   assign delta_in  = comb_full[59:16];

   always_comb begin
      if (yshift[57:31] == '0 || yshift[57:31] == '1) begin
         ystep_in = yshift[31:0];
      end else if (yshift[57]) begin
         ystep_in = {1'b1, 31'd0};
      end else begin
         ystep_in = {1'b0, {31{1'b1}}};
      end
   end

   assign sin_idx  = heading_ff[31 -: TRIG_INDEX_BITS];
   assign rom_addr = cmd.rom_cos ? (sin_idx + QUARTER_IDX) : sin_idx;

   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_TAB[rom_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_scale_ff  <= LEFT_SCALE_RESET;
         right_scale_ff <= RIGHT_SCALE_RESET;
         inv_track_ff   <= INVERSE_TRACK_RESET;
         x_ff           <= '0;
         y_ff           <= '0;
         heading_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_LEFT_SCALE:    left_scale_ff  <= csr_wdata;
               CSR_RIGHT_SCALE:   right_scale_ff <= csr_wdata;
               CSR_INVERSE_TRACK: inv_track_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.ld_x) begin
            x_ff <= sat_pos({x_ff[47], x_ff} + {{5{delta_ff[43]}}, delta_ff});
         end
         if (cmd.ld_y) begin
            y_ff       <= sat_pos({y_ff[47], y_ff} + {{5{delta_ff[43]}}, delta_ff});
            heading_ff <= heading_ff + ystep_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load_in) begin
         right_cnt_ff <= req_right_count;
         left_cnt_ff  <= req_left_count;
      end
      if (cmd.ld_sin) begin
         sin_ff <= rom_q_ff;
      end
      if (cmd.ld_cos) begin
         cos_ff <= rom_q_ff;
      end
      if (cmd.ld_rdist) begin
         rdist_ff <= prod_ff[40:0];
      end
      if (cmd.ld_sum) begin
         lin_ff  <= lin_in;
         diff_ff <= diff_in;
      end
      if (cmd.ld_part) begin
         part_ff <= prod_ff;
      end
      if (cmd.ld_ystep) begin
         ystep_ff <= ystep_in;
      end
      if (cmd.ld_delta) begin
         delta_ff <= delta_in;
      end
      if (cmd.ld_rsp) begin
         pos_x_ff     <= x_ff[47:16];
         pos_y_ff     <= y_ff[47:16];
         yaw_ff       <= heading_ff[31:16];
         lin_out_ff   <= lin_ff;
         ystep_out_ff <= ystep_ff;
      end
   end

   assign rsp_pos_x    = pos_x_ff;
   assign rsp_pos_y    = pos_y_ff;
   assign rsp_yaw      = yaw_ff;
   assign rsp_lin_step = lin_out_ff;
   assign rsp_yaw_step = ystep_out_ff;

endmodule

// ===== sv/diff_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// Differential drive odometry
// Each request carries signed right and left encoder counts for one tick and
// returns the updated pose (Q16.16 x and y, saturated; heading in 2^-16 turn,
// wrapping) with the forward and heading steps of that tick. One request is
// worked at a time; from acceptance to the result being shown it makes
// eight passes through the one shared 25x25 multiplier (two wheel
// scalings, two halves of the heading product, two halves each of the cosine
// and sine products), plus sum, accumulate and result-load steps. No new
// request is accepted until the result is loaded; the next request is then
// accepted in the idle state while that result may still be stalled at the
// output. Scale registers must be written through the csr port only while
// idle; the block itself does not enforce it. No clearing pass follows
// reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diff_drive_odometry (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_right_count,
   input  logic signed [15:0] req_left_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [15:0]        rsp_yaw,
   output logic signed [39:0] rsp_lin_step,
   output logic signed [31:0] rsp_yaw_step,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   import ddo_pkg::*;

   dp_cmd_type dp_cmd;
   logic       req_take;
   logic       rsp_hold;

   ddo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (dp_cmd)
   );

   ddo_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_right_count (req_right_count),
      .req_left_count  (req_left_count),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_yaw         (rsp_yaw),
      .rsp_lin_step    (rsp_lin_step),
      .rsp_yaw_step    (rsp_yaw_step)
   );

   assign req_take = req_valid && !req_stall;
   assign rsp_hold = rsp_valid && rsp_stall;

`include "diff_drive_odometry_assert.svh"

   `DDO_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, req_stall, "not busy")
   `DDO_ASSERT_SAME(a_no_overwrite, clock, reset, dp_cmd.ld_rsp, !rsp_hold, "overwrite")
   `DDO_ASSERT_NEXT(a_valid_after_load, clock, reset, dp_cmd.ld_rsp, rsp_valid, "no valid")

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Differential drive odometry testbench
// Drives encoder count requests through the valid/stall handshake while the
// result side stalls at random, and predicts each pose update in a scoreboard
// from its own copy of the scales, pose and sine table. Covers field extremes,
// heading step saturation, heading wrap, position saturation high on one axis
// and low on the other, ignored register index, and several scale settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import ddo_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 24;
   localparam int DIRECTED_COUNT = 20;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic [23:0] SCALE_MAX = 24'hFFFFFF;
   localparam logic [23:0] STEER_SCALE = 24'h010000;
   localparam logic [15:0] YAW_CORNER = 16'hE000;
   localparam logic signed [63:0] POS_MAX = 64'sh00007FFFFFFFFFFF;
   localparam logic signed [63:0] POS_MIN = 64'shFFFF800000000000;
   localparam logic signed [79:0] STEP_MAX = 80'sd2147483647;
   localparam logic signed [79:0] STEP_MIN = -80'sd2147483648;
   localparam logic [63:0] SIN_C1 = 64'd1686629713;
   localparam logic [63:0] SIN_C3 = 64'd693598668;
   localparam logic [63:0] SIN_C5 = 64'd85569306;
   localparam logic [63:0] SIN_C7 = 64'd5026995;
   localparam logic [63:0] SIN_C9 = 64'd172272;

   localparam logic signed [15:0] DIR_RIGHT [DIRECTED_COUNT] = '{
      16'sd0, 16'sd1, 16'sd0, -16'sd1, 16'sd0, 16'sd32767, -16'sd32768, 16'sd32767,
      -16'sd32768, 16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 16'sd1, -16'sd1, 16'sd100,
      16'sd16384, -16'sd1, 16'sd21845, 16'sd12345};
   localparam logic signed [15:0] DIR_LEFT [DIRECTED_COUNT] = '{
      16'sd0, 16'sd0, 16'sd1, 16'sd0, -16'sd1, 16'sd32767, -16'sd32768, -16'sd32768,
      16'sd32767, 16'sd0, 16'sd32767, 16'sd0, -16'sd32768, -16'sd1, 16'sd1, -16'sd100,
      -16'sd16384, -16'sd1, -16'sd21846, -16'sd4321};

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        yaw;
      logic signed [39:0] lin_step;
      logic signed [31:0] yaw_step;
   } pose_rsp_type;

   class odometry_scoreboard;
      logic [23:0]        left_scale;
      logic [23:0]        right_scale;
      logic [23:0]        inv_track;
      logic signed [63:0] x_pos;
      logic signed [63:0] y_pos;
      logic [31:0]        heading;
      logic signed [17:0] sine_q [TRIG_SIZE];
      pose_rsp_type       pose_q [$];
      int                 errors;

      function new();
         int unsigned quarter;
         int unsigned q;
         int unsigned r;
         logic signed [17:0] v;
         quarter = TRIG_SIZE / 4;
         for (int k = 0; k < TRIG_SIZE; k++) begin
            q = k / quarter;
            r = k % quarter;
            v = q[0] ? quarter_wave(quarter - r) : quarter_wave(r);
            sine_q[k] = q[1] ? -v : v;
         end
         left_scale = LEFT_SCALE_RESET;
         right_scale = RIGHT_SCALE_RESET;
         inv_track = INVERSE_TRACK_RESET;
         x_pos = '0;
         y_pos = '0;
         heading = '0;
         errors = 0;
      endfunction

      // Taylor series of sin(pi/2 * u) in Q2.30, rounded into Q1.16
      function logic signed [17:0] quarter_wave(int unsigned r);
         logic [63:0] u;
         logic [63:0] u2;
         logic [63:0] t;
         logic [63:0] s;
         u = 64'(r) << (30 - (TRIG_INDEX_BITS - 2));
         u2 = (u * u) >> 30;
         t = SIN_C9;
         t = SIN_C7 - ((u2 * t) >> 30);
         t = SIN_C5 - ((u2 * t) >> 30);
         t = SIN_C3 - ((u2 * t) >> 30);
         t = SIN_C1 - ((u2 * t) >> 30);
         s = (u * t) >> 30;
         s = (s + 64'd8192) >> 14;
         if (s > 64'd65536) begin
            s = 64'd65536;
         end
         return $signed(s[17:0]);
      endfunction

      function logic signed [63:0] clamp_pos(logic signed [63:0] v);
         if (v > POS_MAX) begin
            return POS_MAX;
         end
         if (v < POS_MIN) begin
            return POS_MIN;
         end
         return v;
      endfunction

      function void set_reg(logic [1:0] idx, logic [23:0] value);
         case (idx)
            CSR_LEFT_SCALE: left_scale = value;
            CSR_RIGHT_SCALE: right_scale = value;
            CSR_INVERSE_TRACK: inv_track = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return pose_q.size();
      endfunction

      function void note_request(logic signed [15:0] right, logic signed [15:0] left);
         logic signed [63:0] rdist;
         logic signed [63:0] ldist;
         logic signed [63:0] lin;
         logic signed [63:0] dx;
         logic signed [63:0] dy;
         logic signed [63:0] shifted;
         logic signed [79:0] turn;
         logic signed [31:0] ystep;
         int unsigned        sin_i;
         int unsigned        cos_i;
         pose_rsp_type       pose;
         rdist = $signed(right) * $signed({1'b0, right_scale});
         ldist = $signed(left) * $signed({1'b0, left_scale});
         lin = (rdist + ldist) >>> 1;
         turn = (rdist - ldist) * $signed({1'b0, inv_track});
         turn = turn >>> 16;
         if (turn > STEP_MAX) begin
            ystep = 32'sh7FFFFFFF;
         end else if (turn < STEP_MIN) begin
            ystep = 32'sh80000000;
         end else begin
            ystep = turn[31:0];
         end
         sin_i = heading >> (32 - TRIG_INDEX_BITS);
         cos_i = (sin_i + TRIG_SIZE / 4) % TRIG_SIZE;
         dx = (lin * sine_q[cos_i]) >>> 16;
         dy = (lin * sine_q[sin_i]) >>> 16;
         x_pos = clamp_pos(x_pos + dx);
         y_pos = clamp_pos(y_pos + dy);
         heading = heading + ystep;
         shifted = x_pos >>> 16;
         pose.pos_x = shifted[31:0];
         shifted = y_pos >>> 16;
         pose.pos_y = shifted[31:0];
         pose.yaw = heading[31:16];
         pose.lin_step = lin[39:0];
         pose.yaw_step = ystep;
         pose_q.push_back(pose);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic signed [31:0] px, logic signed [31:0] py,
                                 logic [15:0] yaw, logic signed [39:0] lin,
                                 logic signed [31:0] ystep);
         pose_rsp_type want;
         if (pose_q.size() == 0) begin
            $display("%0t: unexpected result, expected none actual x=%h y=%h yaw=%h",
                     $time, px, py, yaw);
            errors++;
            return;
         end
         want = pose_q.pop_front();
         compare_field("pos_x", 64'(want.pos_x), 64'(px));
         compare_field("pos_y", 64'(want.pos_y), 64'(py));
         compare_field("yaw", 64'(want.yaw), 64'(yaw));
         compare_field("lin_step", 64'(want.lin_step), 64'(lin));
         compare_field("yaw_step", 64'(want.yaw_step), 64'(ystep));
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_right_count = '0;
   logic signed [15:0] req_left_count = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic [15:0]        rsp_yaw;
   logic signed [39:0] rsp_lin_step;
   logic signed [31:0] rsp_yaw_step;
   logic               csr_write_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [23:0]        csr_wdata = '0;

   bit                 gaps_on = 1'b0;
   bit                 stalls_on = 1'b0;
   int unsigned        cycle_count = 0;
   odometry_scoreboard sb = new();

   diff_drive_odometry DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_right_count (req_right_count),
      .req_left_count  (req_left_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_yaw         (rsp_yaw),
      .rsp_lin_step    (rsp_lin_step),
      .rsp_yaw_step    (rsp_yaw_step),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_pos_x, rsp_pos_y, rsp_yaw, rsp_lin_step, rsp_yaw_step);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_request(input logic signed [15:0] right, input logic signed [15:0] left);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_right_count <= right;
      req_left_count <= left;
      do @(posedge clock); while (req_stall);
      sb.note_request(right, left);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [23:0] left, input logic [23:0] right,
                            input logic [23:0] track);
      pause_until_drained();
      write_reg(CSR_LEFT_SCALE, left);
      write_reg(CSR_RIGHT_SCALE, right);
      write_reg(CSR_INVERSE_TRACK, track);
   endtask

   // one request turns the heading by exactly the wanted number of yaw units
   task automatic steer_to(input logic [15:0] target);
      logic [15:0] delta;
      configure(STEER_SCALE, STEER_SCALE, STEER_SCALE);
      delta = target - sb.heading[31:16];
      send_request($signed(delta), 16'sd0);
   endtask

   task automatic drive_to_corner(input logic signed [63:0] x_limit,
                                  input logic signed [63:0] y_limit);
      int n;
      int extra;
      configure(SCALE_MAX, SCALE_MAX, 24'd0);
      n = 0;
      extra = 0;
      while (extra < 8 && n < 1500) begin
         send_request(16'($urandom_range(28000, 32767)), 16'($urandom_range(28000, 32767)));
         n++;
         if (sb.x_pos == x_limit && sb.y_pos == y_limit) begin
            extra++;
         end
      end
   endtask

   function automatic logic signed [15:0] pick_count();
      case ($urandom_range(0, 3))
         0: return 16'($urandom());
         1: return 16'($urandom_range(0, 128) - 64);
         2: return $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 15))
                                        : 16'sh8000 + 16'($urandom_range(0, 15));
         default: return 16'($urandom_range(0, 4000) - 2000);
      endcase
   endfunction

   function automatic logic [23:0] pick_scale();
      return 24'($urandom_range(0, SCALE_MAX) >> $urandom_range(0, 23));
   endfunction

   task automatic random_requests(input int count);
      logic signed [15:0] right;
      for (int i = 0; i < count; i++) begin
         right = pick_count();
         send_request(right, $urandom_range(0, 2) == 0 ? right : pick_count());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gaps_on = 1'b1;
      stalls_on = 1'b1;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_request(DIR_RIGHT[i], DIR_LEFT[i]);
      end

      configure(24'd0, 24'd0, 24'd0);
      random_requests(4);
      configure(SCALE_MAX, SCALE_MAX, SCALE_MAX);
      write_reg(CSR_UNUSED, 24'($urandom()));
      send_request(16'sd32767, -16'sd32768);
      send_request(-16'sd32768, 16'sd32767);
      send_request(16'sd32767, 16'sd32767);
      send_request(-16'sd1, 16'sd1);

      // push x to its upper limit and y to its lower limit
      steer_to(YAW_CORNER);
      drive_to_corner(POS_MAX, POS_MIN);

      configure(LEFT_SCALE_RESET, RIGHT_SCALE_RESET, INVERSE_TRACK_RESET);
      random_requests(120);
      configure(pick_scale(), pick_scale(), pick_scale());
      random_requests(120);
      stalls_on = 1'b0;
      configure(pick_scale(), pick_scale(), SCALE_MAX);
      random_requests(40);
      stalls_on = 1'b1;
      gaps_on = 1'b0;
      configure(SCALE_MAX, 24'd0, pick_scale());
      random_requests(40);
      gaps_on = 1'b1;
      configure(24'($urandom_range(0, 4095)), 24'($urandom_range(0, 4095)), pick_scale());
      random_requests(40);

      gaps_on = 1'b0;
      stalls_on = 1'b0;
      configure(pick_scale(), pick_scale(), pick_scale());
      random_requests(80);

      pause_until_drained();
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ddo_pkg.sv
sv/ddo_ctrl.sv
sv/ddo_datapath.sv
sv/diff_drive_odometry.sv
test/tb_top.sv
